>>> hw/rtl/jss_pkg.sv
// jss_pkg: shared types and constants for the jump search table
// no dependencies; imported by every module of the block
package jss_pkg;

    localparam int TABLE_DEPTH_DEF = 1024;
    localparam int KEY_W    = 32;
    localparam int INDEX_W  = 10;
    localparam int LEN_W    = 11;
    localparam int CNT_W    = LEN_W + 1;
    localparam int STRIDE_W = 6;
    localparam int SQ_BIT_W = 3;

    localparam logic MODE_LOAD   = 1'b0;
    localparam logic MODE_SEARCH = 1'b1;

    typedef struct packed {
        logic accept;
        logic rd_jump;
        logic rd_scan;
        logic adv_jump;
        logic adv_scan;
        logic set_result;
        logic result_found;
    } cmd_t;

    typedef struct packed {
        logic stride_busy;
        logic n_zero;
        logic probe_ge;
        logic probe_eq;
        logic step_ge_n;
        logic low_last;
    } stat_t;

endpackage

>>> hw/rtl/jump_search_sorted_table.sv
// jump_search_sorted_table: sorted table with jump search lookup
// a load word is written when it is accepted, and the block stays ready for the next word;
//   a search reads and compares a block end per jump probe, then an entry per scan probe,
//   at most 64 probes at 1024 entries, paced by the single registered read port of the
//   table memory; one word in flight. A length write starts a square root; items stall
//   in the write cycle and until the stride is ready
// reset clears the sequencer, the result valid, the length and the stride; the table
// memory is not cleared and holds garbage until loaded
module jump_search_sorted_table
    import jss_pkg::*;
#(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    // table length register
    input  logic                    length_we,
    input  logic [LEN_W-1:0]        length_data,
    // input word channel
    input  logic                    item_valid,
    output logic                    item_stall,
    input  logic                    mode,
    input  logic [INDEX_W-1:0]      index,
    input  logic signed [KEY_W-1:0] value,
    // result word channel
    output logic                    result_valid,
    input  logic                    result_stall,
    output logic                    found,
    output logic [INDEX_W-1:0]      position
);

    cmd_t  cmd;
    stat_t stat;

    // sequencer: jump probes on block ends, then a linear scan of one block
    jss_ctrl u_ctrl
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .mode         (mode),
        .length_we    (length_we),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .stat         (stat),
        .cmd          (cmd)
    );

    // memory, key and index counters, stride unit, result register
    jss_datapath #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_datapath
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .length_we   (length_we),
        .length_data (length_data),
        .mode        (mode),
        .index       (index),
        .value       (value),
        .cmd         (cmd),
        .stat        (stat),
        .found       (found),
        .position    (position)
    );

endmodule

>>> hw/rtl/jss_isqrt.sv
// jss_isqrt: bit-serial integer square root, one result bit per cycle
// depends on jss_pkg
module jss_isqrt
    import jss_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic [LEN_W-1:0]    operand,
    output logic                busy,
    output logic [STRIDE_W-1:0] root
);

    logic [LEN_W-1:0]    op_reg;
    logic [STRIDE_W-1:0] root_reg;
    logic [SQ_BIT_W-1:0] bit_reg;
    logic                busy_reg;
    logic [STRIDE_W-1:0] trial;
    logic [2*STRIDE_W-1:0] trial_sq;

    always_comb
    begin
        trial    = root_reg | (STRIDE_W'(1) << bit_reg);
        trial_sq = (2*STRIDE_W)'(trial) * (2*STRIDE_W)'(trial);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            root_reg <= '0;
            bit_reg  <= '0;
            busy_reg <= 1'b0;
        end
        else if (start)
        begin
            root_reg <= '0;
            bit_reg  <= SQ_BIT_W'(STRIDE_W - 1);
            busy_reg <= 1'b1;
        end
        else if (busy_reg)
        begin
            if (trial_sq <= (2*STRIDE_W)'(op_reg))
                root_reg <= trial;
            if (bit_reg == '0)
                busy_reg <= 1'b0;
            else
                bit_reg <= bit_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
            op_reg <= operand;
    end

    assign busy = busy_reg;
    assign root = root_reg;

endmodule

>>> hw/rtl/jss_datapath.sv
// jss_datapath: table memory, search registers, stride unit and result word
// depends on jss_pkg and jss_isqrt
module jss_datapath
    import jss_pkg::*;
#(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     length_we,
    input  logic [LEN_W-1:0]         length_data,
    input  logic                     mode,
    input  logic [INDEX_W-1:0]       index,
    input  logic signed [KEY_W-1:0]  value,
    input  cmd_t                     cmd,
    output stat_t                    stat,
    output logic                     found,
    output logic [INDEX_W-1:0]       position
);

    localparam int ADDR_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

    logic signed [KEY_W-1:0] mem [TABLE_DEPTH];
    logic signed [KEY_W-1:0] rdata_reg;
    logic signed [KEY_W-1:0] key_reg;
    logic [LEN_W-1:0]        n_reg;
    logic [LEN_W-1:0]        n_clamp;
    logic [CNT_W-1:0]        step_reg;
    logic [CNT_W-1:0]        low_reg;
    logic [CNT_W-1:0]        limit;
    logic [ADDR_W-1:0]       raddr;
    logic                    found_reg;
    logic [INDEX_W-1:0]      position_reg;
    logic                    sq_busy;
    logic [STRIDE_W-1:0]     stride;
    logic                    load_ok;

    // saturate the length at the table depth
    always_comb
    begin
        if (32'(length_data) > 32'(TABLE_DEPTH))
            n_clamp = LEN_W'(TABLE_DEPTH);
        else
            n_clamp = length_data;
    end

    jss_isqrt u_isqrt
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (length_we),
        .operand (n_clamp),
        .busy    (sq_busy),
        .root    (stride)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            n_reg <= '0;
        else if (length_we)
            n_reg <= n_clamp;
    end

    always_comb
    begin
        limit   = (step_reg < CNT_W'(n_reg)) ? step_reg : CNT_W'(n_reg);
        raddr   = cmd.rd_jump ? ADDR_W'(limit - 1'b1) : ADDR_W'(low_reg);
        load_ok = (mode == MODE_LOAD) && (32'(index) < 32'(TABLE_DEPTH));
    end

    // one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (cmd.accept && load_ok)
            mem[ADDR_W'(index)] <= value;
        if (cmd.rd_jump || cmd.rd_scan)
            rdata_reg <= mem[raddr];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            key_reg  <= value;
            step_reg <= CNT_W'(stride);
            low_reg  <= '0;
        end
        else if (cmd.adv_jump)
        begin
            low_reg  <= step_reg;
            step_reg <= step_reg + CNT_W'(stride);
        end
        else if (cmd.adv_scan)
        begin
            low_reg <= low_reg + 1'b1;
        end

        if (cmd.set_result)
        begin
            found_reg    <= cmd.result_found;
            position_reg <= cmd.result_found ? INDEX_W'(low_reg) : '0;
        end
    end

    always_comb
    begin
        stat.stride_busy = sq_busy;
        stat.n_zero      = (n_reg == '0) || (stride == '0);
        stat.probe_ge    = rdata_reg >= key_reg;
        stat.probe_eq    = rdata_reg == key_reg;
        stat.step_ge_n   = step_reg >= CNT_W'(n_reg);
        stat.low_last    = (low_reg + 1'b1) == limit;
    end

    assign found    = found_reg;
    assign position = position_reg;

endmodule

>>> hw/rtl/jss_ctrl.sv
// jss_ctrl: search sequencer and output handshake
// depends on jss_pkg; drives the command word of jss_datapath
module jss_ctrl
    import jss_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  item_valid,
    output logic  item_stall,
    input  logic  mode,
    input  logic  length_we,
    output logic  result_valid,
    input  logic  result_stall,
    input  stat_t stat,
    output cmd_t  cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_START,
        ST_JREAD,
        ST_JCMP,
        ST_SREAD,
        ST_SCMP
    } state_t;

    state_t state_reg, state_next;
    logic   result_valid_reg, result_valid_next;
    logic   slot_free;

    always_comb
    begin
        slot_free  = !result_valid_reg || !result_stall;
        item_stall = (state_reg != ST_IDLE) || stat.stride_busy || length_we;

        cmd               = '0;
        state_next        = state_reg;
        result_valid_next = result_valid_reg && result_stall;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (item_valid && !item_stall)
                begin
                    cmd.accept = 1'b1;
                    if (mode == MODE_SEARCH)
                        state_next = ST_START;
                end
            end
            ST_START:
            begin
                if (!stat.n_zero)
                    state_next = ST_JREAD;
                else if (slot_free)
                begin
                    cmd.set_result    = 1'b1;
                    result_valid_next = 1'b1;
                    state_next        = ST_IDLE;
                end
            end
            ST_JREAD:
            begin
                cmd.rd_jump = 1'b1;
                state_next  = ST_JCMP;
            end
            ST_JCMP:
            begin
                if (stat.probe_ge)
                    state_next = ST_SREAD;
                else if (!stat.step_ge_n)
                begin
                    cmd.adv_jump = 1'b1;
                    state_next   = ST_JREAD;
                end
                else if (slot_free)
                begin
                    cmd.set_result    = 1'b1;
                    result_valid_next = 1'b1;
                    state_next        = ST_IDLE;
                end
            end
            ST_SREAD:
            begin
                cmd.rd_scan = 1'b1;
                state_next  = ST_SCMP;
            end
            ST_SCMP:
            begin
                if (!stat.probe_ge && !stat.low_last)
                begin
                    cmd.adv_scan = 1'b1;
                    state_next   = ST_SREAD;
                end
                else if (slot_free)
                begin
                    cmd.set_result    = 1'b1;
                    cmd.result_found  = stat.probe_eq;
                    result_valid_next = 1'b1;
                    state_next        = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            result_valid_reg <= result_valid_next;
        end
    end

    assign result_valid = result_valid_reg;

endmodule
